@@ sv/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants shared by the 2x2 RGBA box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int CH_W       = 8;
  localparam int PAIR_W     = CH_W + 1;
  localparam int SUM_W      = CH_W + 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int HEIGHT_LIMIT = 4096;

  typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CH_W-1:0]       chan_t;
  typedef logic [3:0][CH_W-1:0]  pixel_t;
  typedef logic [3:0][PAIR_W-1:0] pair_t;

  localparam cfg_index_t REG_WIDTH  = cfg_index_t'(0);
  localparam cfg_index_t REG_HEIGHT = cfg_index_t'(1);

  typedef struct packed {
    logic use_mem;
    logic eor;
    logic eof;
  } s1_ctrl_t;

endpackage

@@ sv/rgba_box_downsample_2x2.sv @@
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2
// Streaming 2x2 box-filter downsampler for RGBA8 raster images.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : raster pixels, taken when in_valid is high and in_stall is low
//   out_* : averaged pixels of the next mip level, taken when out_valid is
//           high and out_stall is low; out_end_of_row / out_end_of_frame mark
//           the last word of an output row and of the image
//   cfg_* : register writes (index 0 width, index 1 height), always ready;
//           a write to either register restarts the frame
// Timing
//   one pixel accepted per clock while in_stall is low; a result passes
//   through the stage 1 register, beside the registered line store read,
//   and then the output register
//   the line store has one write and one read port: even rows write
//   horizontal pair sums, odd rows read them back
// Reset
//   width and height return to 1 and the raster position to the origin;
//   the line store is not cleared, it is always written before it is read
// Stall
//   a stalled output word holds; the pipeline stage behind it holds too and
//   in_stall rises only when that stage is full and cannot move on
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbd_pkg::chan_t     in_red,
  input  rbd_pkg::chan_t     in_green,
  input  rbd_pkg::chan_t     in_blue,
  input  rbd_pkg::chan_t     in_alpha,
  output logic               out_valid,
  input  logic               out_stall,
  output rbd_pkg::chan_t     out_red,
  output rbd_pkg::chan_t     out_green,
  output rbd_pkg::chan_t     out_blue,
  output rbd_pkg::chan_t     out_alpha,
  output logic               out_end_of_row,
  output logic               out_end_of_frame,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rbd_pkg::cfg_index_t cfg_index,
  input  rbd_pkg::cfg_data_t cfg_data
);
  import rbd_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);

  // configuration
  cfg_data_t width_r, height_r;
  logic      cfg_wr, cfg_hit;

  logic [WIDTH_W-1:0]  eff_w, nw_m1, w_m1;
  logic [HEIGHT_W-1:0] eff_h, nh_m1, h_m1;
  logic [31:0]         w_sat, h_sat;
  logic                w_is1, h_is1;

  // raster position
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_col, last_row, col_drop, row_drop;

  // stage 0
  logic          acc;
  pixel_t        px, left_r;
  pair_t         pair0;
  logic          have_pair, mem_wr, mem_rd, emit0, eor0, eof0;
  logic [AW-1:0] addr;
  logic [CNT_W-1:0] j_full;
  logic [ROW_W-1:0] i_full;

  // line store
  pair_t pair_mem [STORE_DEPTH];
  pair_t rd_data_r;

  // stage 1 and output
  logic     s1_valid_r, s1_valid_nxt, s1_adv;
  pair_t    s1_pair_r;
  s1_ctrl_t s1_ctrl_r;
  pixel_t   avg;
  logic [SUM_W-1:0] sum [4];
  logic     out_valid_r, out_valid_nxt;
  pixel_t   out_pix_r;
  logic     out_eor_r, out_eof_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cfg_data_t'(1);
      height_r <= cfg_data_t'(1);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes, zero taken as 1 and saturated at the limits
  always_comb begin
    w_sat = 32'(width_r);
    if (w_sat == 32'd0)              w_sat = 32'd1;
    if (w_sat > 32'(MAX_WIDTH))      w_sat = 32'(MAX_WIDTH);
    h_sat = 32'(height_r);
    if (h_sat == 32'd0)              h_sat = 32'd1;
    if (h_sat > 32'(HEIGHT_LIMIT))   h_sat = 32'(HEIGHT_LIMIT);
    eff_w = WIDTH_W'(w_sat);
    eff_h = HEIGHT_W'(h_sat);
    w_is1 = (eff_w == WIDTH_W'(1));
    h_is1 = (eff_h == HEIGHT_W'(1));
    w_m1  = eff_w - WIDTH_W'(1);
    h_m1  = eff_h - HEIGHT_W'(1);
    nw_m1 = w_is1 ? '0 : (eff_w >> 1) - WIDTH_W'(1);
    nh_m1 = h_is1 ? '0 : (eff_h >> 1) - HEIGHT_W'(1);
  end

  assign acc = in_valid && !in_stall;
  assign px  = {in_alpha, in_blue, in_green, in_red};

  always_comb begin
    last_col  = (WIDTH_W'(col_r) == w_m1);
    last_row  = (HEIGHT_W'(row_r) == h_m1);
    col_drop  = !w_is1 && eff_w[0] && last_col;
    row_drop  = !h_is1 && eff_h[0] && last_row;
    have_pair = w_is1 || (!col_drop && col_r[0]);
    j_full    = col_r >> 1;
    i_full    = row_r >> 1;
    addr      = w_is1 ? '0 : AW'(j_full);
    for (int k = 0; k < 4; k++) begin
      pair0[k] = w_is1 ? {px[k], 1'b0} : PAIR_W'(left_r[k]) + PAIR_W'(px[k]);
    end
    mem_wr = acc && have_pair && !h_is1 && !row_drop && !row_r[0];
    mem_rd = acc && have_pair && !h_is1 && !row_drop && row_r[0];
    emit0  = acc && have_pair && (h_is1 || (!row_drop && row_r[0]));
    eor0   = w_is1 || (WIDTH_W'(j_full) == nw_m1);
    eof0   = eor0 && (h_is1 || (HEIGHT_W'(i_full) == nh_m1));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // even-column pixel waiting for its partner
  always_ff @(posedge clk) begin
    if (acc && !w_is1 && !col_drop && !col_r[0]) begin
      left_r <= px;
    end
  end

  // line store: writes and reads of one entry never fall on the same edge
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      pair_mem[addr] <= pair0;
    end
    if (mem_rd) begin
      rd_data_r <= pair_mem[addr];
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (emit0)       s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_adv)         out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit0) begin
      s1_pair_r         <= pair0;
      s1_ctrl_r.use_mem <= !h_is1;
      s1_ctrl_r.eor     <= eor0;
      s1_ctrl_r.eof     <= eof0;
    end
  end

  // vertical sum and truncated mean
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = s1_ctrl_r.use_mem ? SUM_W'(rd_data_r[k]) + SUM_W'(s1_pair_r[k])
                                 : {s1_pair_r[k], 1'b0};
      avg[k] = sum[k][SUM_W-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r <= avg;
      out_eor_r <= s1_ctrl_r.eor;
      out_eof_r <= s1_ctrl_r.eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_pix_r[0];
  assign out_green        = out_pix_r[1];
  assign out_blue         = out_pix_r[2];
  assign out_alpha        = out_pix_r[3];
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WIDTH_W'(col_r) < eff_w)
    else $error("column position beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    HEIGHT_W'(row_r) < eff_h)
    else $error("row position beyond image height");

  a_read_feeds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd |=> s1_valid_r && s1_ctrl_r.use_mem)
    else $error("line store read without a waiting stage word");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && mem_wr))
    else $error("line store read and write in one cycle");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 2x2 RGBA box downsampler. Raster
// pixels go in under random gaps and output stalls. A scoreboard keeps its
// own line store and raster position to predict each averaged word, with
// its row and frame end flags. It compares every word that leaves the block
// against the oldest prediction. Several image sizes are run: the smallest,
// odd and saturated sizes, broken frames and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
  import rbd_pkg::*;

  localparam int MAX_W = 4096;
  localparam int LINE_DEPTH = MAX_W / 2;
  localparam int N_ITEMS = 1050;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  eor;
    logic  eof;
  } mip_word_t;

  class mip_checker;
    cfg_data_t   width_reg;
    cfg_data_t   height_reg;
    pair_t       pair_line [LINE_DEPTH];
    pixel_t      left_px;
    int unsigned col;
    int unsigned row;
    mip_word_t   expected_words [$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned words;
    int unsigned frames;

    function new();
      width_reg  = 1;
      height_reg = 1;
      left_px    = '0;
      col        = 0;
      row        = 0;
      errors     = 0;
      pixels     = 0;
      words      = 0;
      frames     = 0;
    endfunction

    function void write_reg(cfg_index_t idx, cfg_data_t data);
      if (idx == REG_WIDTH) begin
        width_reg = data;
      end else if (idx == REG_HEIGHT) begin
        height_reg = data;
      end else begin
        return;
      end
      col = 0;
      row = 0;
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned w;
      int unsigned h;
      int unsigned nw;
      int unsigned nh;
      int unsigned j;
      int unsigned i;
      int          k;
      logic        have_pair;
      logic        emit;
      pair_t       pr;
      logic [SUM_W-1:0] s [4];
      mip_word_t   exp_word;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      h = (height_reg == 0) ? 1 :
          ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
      nw = (w / 2 < 1) ? 1 : w / 2;
      nh = (h / 2 < 1) ? 1 : h / 2;
      have_pair = 1'b0;
      emit = 1'b0;
      j = 0;
      i = 0;
      pr = '0;
      pixels++;
      // horizontal pair
      if (w == 1) begin
        for (k = 0; k < 4; k++) pr[k] = {px[k], 1'b0};
        have_pair = 1'b1;
      end else if (col < 2 * nw) begin
        if (col % 2 == 0) begin
          left_px = px;
        end else begin
          for (k = 0; k < 4; k++) pr[k] = PAIR_W'(left_px[k]) + PAIR_W'(px[k]);
          have_pair = 1'b1;
          j = col / 2;
        end
      end
      // vertical pair
      if (have_pair && j < LINE_DEPTH) begin
        if (h == 1) begin
          for (k = 0; k < 4; k++) s[k] = {pr[k], 1'b0};
          emit = 1'b1;
        end else if (row < 2 * nh) begin
          if (row % 2 == 0) begin
            pair_line[j] = pr;
          end else begin
            for (k = 0; k < 4; k++) s[k] = SUM_W'(pair_line[j][k]) + SUM_W'(pr[k]);
            emit = 1'b1;
            i = row / 2;
          end
        end
        if (emit) begin
          exp_word.red   = s[0][SUM_W-1:2];
          exp_word.green = s[1][SUM_W-1:2];
          exp_word.blue  = s[2][SUM_W-1:2];
          exp_word.alpha = s[3][SUM_W-1:2];
          exp_word.eor   = (j == nw - 1);
          exp_word.eof   = (j == nw - 1) && (i == nh - 1);
          expected_words.push_back(exp_word);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function string fmt(mip_word_t x);
      return $sformatf("r=%02h g=%02h b=%02h a=%02h eor=%0b eof=%0b",
                       x.red, x.green, x.blue, x.alpha, x.eor, x.eof);
    endfunction

    function void check_word(mip_word_t got);
      mip_word_t exp_word;
      words++;
      if (got.eof) frames++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("word %0d not expected: %s", words, fmt(got));
        return;
      end
      exp_word = expected_words.pop_front();
      if (got !== exp_word) begin
        errors++;
        if (errors <= 10)
          $display("word %0d mismatch: expected %s, got %s", words,
                   fmt(exp_word), fmt(got));
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  chan_t      in_red = '0;
  chan_t      in_green = '0;
  chan_t      in_blue = '0;
  chan_t      in_alpha = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  chan_t      out_red;
  chan_t      out_green;
  chan_t      out_blue;
  chan_t      out_alpha;
  logic       out_end_of_row;
  logic       out_end_of_frame;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = REG_WIDTH;
  cfg_data_t  cfg_data = '0;

  mip_checker sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int size_settings = 0;
  int sent = 0;

  rgba_box_downsample_2x2 dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls plus long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_stall <= 1'b1;
      hold_done <= hold_req;
      hold_left <= hold_len;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: results are checked before the input of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall)
        sb.check_word({out_red, out_green, out_blue, out_alpha,
                       out_end_of_row, out_end_of_frame});
      if (in_valid && !in_stall)
        sb.note_pixel({in_alpha, in_blue, in_green, in_red});
    end
  end

  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px[0];
    in_green <= px[1];
    in_blue  <= px[2];
    in_alpha <= px[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input cfg_data_t w, input cfg_data_t h);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_settings++;
  endtask

  task automatic send_run(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_pixel(pixel_t'($urandom));
      if ($urandom_range(63) == 0) wait_idle();
    end
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      1: begin
        idle_pct = 50;
        stall_pct <= 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct <= 50;
      end
      default: begin
        idle_pct = 20;
        stall_pct <= 20;
      end
    endcase
  endtask

  function automatic int pick_size(input int mid_max);
    case ($urandom_range(9))
      0: return 1;
      1: return 2;
      2: return 3;
      3: return $urandom_range(13, mid_max);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    int phase;
    int w;
    int h;
    int n;
    phase = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(0);

    // size after reset is 1x1
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00000000);

    write_config(2, 2);
    repeat (4) send_pixel(32'hFFFFFFFF);
    send_pixel(32'h01FF00FF);
    send_pixel(32'h01FF0000);
    send_pixel(32'h0100FF00);
    send_pixel(32'h00FFFF01);

    // odd size drops the last row and column
    write_config(3, 3);
    send_run(9);

    // zero sizes count as one
    write_config(0, 0);
    send_run(1);

    write_config(1, 2);
    send_run(2);
    write_config(2, 1);
    send_run(2);

    // long receiver hold while the sender keeps offering
    write_config(4, 1);
    hold_len <= 100;
    hold_req <= hold_req + 1;
    send_run(64);

    // saturated width on one row, then saturated height on one column
    set_mode(3);
    write_config(13'h1FFF, 1);
    send_run(96);
    set_mode(1);
    write_config(1, 13'h1FFF);
    send_run(96);

    while (sent < N_ITEMS) begin
      set_mode(phase % 4);
      phase++;
      w = pick_size(40);
      h = pick_size(16);
      write_config(w, h);
      if ($urandom_range(4) == 0) n = $urandom_range(1, w * h);
      else n = w * h * $urandom_range(1, 3);
      if (n > N_ITEMS - sent) n = N_ITEMS - sent;
      send_run(n);
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("covered %0d pixels and %0d averaged words with %0d frame ends, %0d sizes",
             sb.pixels, sb.words, sb.frames, size_settings);
    $display("under free flow, sender gaps, output stalls, both, and one long hold");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rbd_pkg.sv
sv/rgba_box_downsample_2x2.sv
verif/tb_top.sv
